### hw/rtl/mlr_pkg.sv
// shared types and constants for the midpoint line rasterizer
// no dependencies; used by midpoint_line_rasterizer
package mlr_pkg;

	localparam int COORD_BITS = 12;
	localparam int DEC_BITS   = COORD_BITS + 4;
	localparam int CNT_BITS   = COORD_BITS + 1;
	localparam int TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int TUSER_BITS = 2;

	typedef logic [COORD_BITS-1:0]   coord_t;
	typedef logic signed [DEC_BITS-1:0] dec_t;
	typedef logic [CNT_BITS-1:0]     cnt_t;

	typedef enum logic [TUSER_BITS-1:0] {
		REQ_MOVE = 2'd0,
		REQ_LINE = 2'd1,
		REQ_STEP = 2'd2
	} req_t;

	// octant pairs, dx >= 0 after the swap
	typedef enum logic [1:0] {
		MODE_X_UP   = 2'd0,
		MODE_Y_UP   = 2'd1,
		MODE_Y_DOWN = 2'd2,
		MODE_X_DOWN = 2'd3
	} mode_t;

endpackage

### hw/rtl/midpoint_line_rasterizer.sv
// midpoint line rasterizer top level: input stage, line setup, pixel stepping, output register
// depends on mlr_pkg
//
// usage:
//   s_axis carries requests: tuser is the request kind (move pen, line to point, step),
//   tdata carries the coordinates. a move sets the pen, a line sets up drawing from the
//   pen to the given point (the pen stays put), each step emits the next pixel of the line.
//   m_axis carries one pixel for each step taken while a line is being drawn; tlast marks
//   the last pixel of the line. the end point on the major axis is not plotted.
//   a step while idle, a move, a line and the unused request code give no item.
// timing:
//   an item is registered at the input, then handled by one pass of setup or step logic
//   into the output register, which drives m_axis_tvalid. one request is taken every cycle
//   unless a stall holds a step; the decision update is one compare and one or two adds.
// reset:
//   arst_n clears the pen, the line state and both valid flags; the block is idle.
// stall:
//   while m_axis_tready is low with a pixel pending, a step waiting in the input stage
//   holds and s_axis_tready drops; requests that give no item still pass.
module midpoint_line_rasterizer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [mlr_pkg::TDATA_BITS-1:0]    s_axis_tdata,  // coord_x, coord_y
	input  logic [mlr_pkg::TUSER_BITS-1:0]    s_axis_tuser,  // req_type
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [mlr_pkg::TDATA_BITS-1:0]    m_axis_tdata,  // pixel_x, pixel_y
	output logic                              m_axis_tlast   // last_pixel
);

	localparam int CB = mlr_pkg::COORD_BITS;
	localparam int DB = mlr_pkg::DEC_BITS;
	localparam int NB = mlr_pkg::CNT_BITS;

	// input stage
	logic                      valid_s1;
	mlr_pkg::req_t             req_s1;
	mlr_pkg::coord_t           x_s1, y_s1;

	// line state
	mlr_pkg::coord_t           pen_x_q, pen_y_q, cur_x_q, cur_y_q;
	mlr_pkg::coord_t           dx_q, ady_q;
	mlr_pkg::dec_t             dec_q;
	mlr_pkg::cnt_t             remaining_q;
	mlr_pkg::mode_t            mode_q;
	logic                      drawing_q;

	// output register
	logic                      out_valid_q;
	mlr_pkg::coord_t           out_x_q, out_y_q;
	logic                      out_last_q;

	logic                      emit, fire;

	// setup
	logic                      swap;
	mlr_pkg::coord_t           sx, sy, ex, ey, dx, ady;
	logic signed [CB:0]        dy;
	logic                      dy_neg, zero_len;
	mlr_pkg::mode_t            mode_n;
	mlr_pkg::dec_t             dxe, adye, dec_init;
	mlr_pkg::cnt_t             rem_init;

	// step
	mlr_pkg::dec_t             dx2, dy2, dec_next;
	mlr_pkg::coord_t           cur_x_next, cur_y_next;
	logic                      last;

	assign emit = (req_s1 == mlr_pkg::REQ_STEP) && drawing_q;
	assign fire = valid_s1 && (!emit || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire;

	always_comb begin
		swap = pen_x_q > x_s1;
		sx = swap ? x_s1 : pen_x_q;
		sy = swap ? y_s1 : pen_y_q;
		ex = swap ? pen_x_q : x_s1;
		ey = swap ? pen_y_q : y_s1;
		dx = ex - sx;
		dy = $signed({1'b0, ey}) - $signed({1'b0, sy});
		dy_neg = dy[CB];
		ady = dy_neg ? CB'(-dy) : CB'(dy);
		zero_len = (dx == '0) && (ady == '0);
		dxe = $signed({{(DB-CB){1'b0}}, dx});
		adye = $signed({{(DB-CB){1'b0}}, ady});
		if (!dy_neg && ady <= dx) begin
			mode_n = mlr_pkg::MODE_X_UP;
		end else if (!dy_neg) begin
			mode_n = mlr_pkg::MODE_Y_UP;
		end else if (ady > dx) begin
			mode_n = mlr_pkg::MODE_Y_DOWN;
		end else begin
			mode_n = mlr_pkg::MODE_X_DOWN;
		end
		unique case (mode_n)
			mlr_pkg::MODE_X_UP: begin
				dec_init = dxe - adye - adye;
				rem_init = NB'(dx);
			end
			mlr_pkg::MODE_Y_UP: begin
				dec_init = dxe + dxe - adye;
				rem_init = NB'(ady);
			end
			mlr_pkg::MODE_Y_DOWN: begin
				dec_init = adye - dxe - dxe;
				rem_init = NB'(ady);
			end
			default: begin
				dec_init = adye + adye - dxe;
				rem_init = NB'(dx);
			end
		endcase
	end

	always_comb begin
		dx2 = $signed({{(DB-CB-1){1'b0}}, dx_q, 1'b0});
		dy2 = $signed({{(DB-CB-1){1'b0}}, ady_q, 1'b0});
		cur_x_next = cur_x_q;
		cur_y_next = cur_y_q;
		dec_next = dec_q;
		unique case (mode_q)
			mlr_pkg::MODE_X_UP: begin
				if (dec_q < 0) begin
					cur_y_next = cur_y_q + 1'b1;
					dec_next = dec_q + dx2 - dy2;
				end else begin
					dec_next = dec_q - dy2;
				end
				cur_x_next = cur_x_q + 1'b1;
			end
			mlr_pkg::MODE_Y_UP: begin
				if (dec_q >= 0) begin
					cur_x_next = cur_x_q + 1'b1;
					dec_next = dec_q + dx2 - dy2;
				end else begin
					dec_next = dec_q + dx2;
				end
				cur_y_next = cur_y_q + 1'b1;
			end
			mlr_pkg::MODE_Y_DOWN: begin
				if (dec_q < 0) begin
					cur_x_next = cur_x_q + 1'b1;
					dec_next = dec_q + dy2 - dx2;
				end else begin
					dec_next = dec_q - dx2;
				end
				cur_y_next = cur_y_q - 1'b1;
			end
			default: begin
				if (dec_q > 0) begin
					cur_y_next = cur_y_q - 1'b1;
					dec_next = dec_q + dy2 - dx2;
				end else begin
					dec_next = dec_q + dy2;
				end
				cur_x_next = cur_x_q + 1'b1;
			end
		endcase
		last = remaining_q <= NB'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1 <= mlr_pkg::req_t'(s_axis_tuser);
			x_s1 <= s_axis_tdata[CB-1:0];
			y_s1 <= s_axis_tdata[2*CB-1:CB];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= '0;
			pen_y_q <= '0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			dx_q <= '0;
			ady_q <= '0;
			dec_q <= '0;
			remaining_q <= '0;
			mode_q <= mlr_pkg::MODE_X_UP;
			drawing_q <= 1'b0;
		end else if (fire) begin
			unique case (req_s1)
				mlr_pkg::REQ_MOVE: begin
					pen_x_q <= x_s1;
					pen_y_q <= y_s1;
				end
				mlr_pkg::REQ_LINE: begin
					drawing_q <= !zero_len;
					if (!zero_len) begin
						mode_q <= mode_n;
						dec_q <= dec_init;
						remaining_q <= rem_init;
						dx_q <= dx;
						ady_q <= ady;
						cur_x_q <= sx;
						cur_y_q <= sy;
					end
				end
				mlr_pkg::REQ_STEP: begin
					if (drawing_q) begin
						if (last) begin
							remaining_q <= '0;
							drawing_q <= 1'b0;
						end else begin
							remaining_q <= remaining_q - 1'b1;
							cur_x_q <= cur_x_next;
							cur_y_q <= cur_y_next;
							dec_q <= dec_next;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_x_q <= cur_x_q;
			out_y_q <= cur_y_q;
			out_last_q <= last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = mlr_pkg::TDATA_BITS'({out_y_q, out_x_q});
	assign m_axis_tlast = out_last_q;

endmodule

### tb/sv/tb.sv
// self-checking testbench for midpoint_line_rasterizer: directed and random requests,
// pixels predicted in the testbench and compared item by item on the master stream
// depends on mlr_pkg and the midpoint_line_rasterizer rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [mlr_pkg::TUSER_BITS-1:0] REQ_UNUSED = 2'd3;
	localparam int TARGET_ITEMS = 1550;
	localparam int IDLE_PCT     = 22;
	localparam int QUIET_FROM   = 600;
	localparam int QUIET_TO     = 900;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 300;
	localparam int PAUSE_AT     = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int COORD_MAX    = (1 << mlr_pkg::COORD_BITS) - 1;
	localparam int CB           = mlr_pkg::COORD_BITS;

	typedef logic [mlr_pkg::TDATA_BITS-1:0] tdata_t;

	typedef struct {
		logic [mlr_pkg::TUSER_BITS-1:0] kind;
		mlr_pkg::coord_t                x;
		mlr_pkg::coord_t                y;
	} request_t;

	typedef struct {
		mlr_pkg::coord_t x;
		mlr_pkg::coord_t y;
		logic            last;
	} pixel_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   s_axis_tvalid = 1'b0;
	logic   s_axis_tready;
	tdata_t s_axis_tdata = '0;
	logic [mlr_pkg::TUSER_BITS-1:0] s_axis_tuser = '0;
	logic   m_axis_tvalid;
	logic   m_axis_tready = 1'b0;
	tdata_t m_axis_tdata;
	logic   m_axis_tlast;

	request_t request_queue[$];
	pixel_t   expected_pixels[$];
	int       items_sent = 0;
	int       cycle_count = 0;
	int       error_count = 0;
	int       hold_left = 0;
	bit       hold_done = 1'b0;
	bit       pause_done = 1'b0;

	// predictor state
	mlr_pkg::coord_t pen_x, pen_y, cur_x, cur_y;
	int              decision, remaining, span_x, span_ay;
	mlr_pkg::mode_t  octant;
	bit              drawing;

	midpoint_line_rasterizer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void start_line(mlr_pkg::coord_t end_x, mlr_pkg::coord_t end_y);
		int sx, sy, ex, ey, dx, dy, ady, t;
		sx = int'(pen_x);
		sy = int'(pen_y);
		ex = int'(end_x);
		ey = int'(end_y);
		if (sx > ex) begin
			t = sx; sx = ex; ex = t;
			t = sy; sy = ey; ey = t;
		end
		dx = ex - sx;
		dy = ey - sy;
		ady = (dy < 0) ? -dy : dy;
		drawing = 1'b0;
		if (dx == 0 && dy == 0)
			return;
		if (dy >= 0 && dy <= dx) begin
			octant = mlr_pkg::MODE_X_UP;
			decision = dx - 2 * ady;
			remaining = dx;
		end else if (dy > dx) begin
			octant = mlr_pkg::MODE_Y_UP;
			decision = 2 * dx - ady;
			remaining = ady;
		end else if (ady > dx) begin
			octant = mlr_pkg::MODE_Y_DOWN;
			decision = ady - 2 * dx;
			remaining = ady;
		end else begin
			octant = mlr_pkg::MODE_X_DOWN;
			decision = 2 * ady - dx;
			remaining = dx;
		end
		span_x = dx;
		span_ay = ady;
		cur_x = mlr_pkg::coord_t'(sx);
		cur_y = mlr_pkg::coord_t'(sy);
		drawing = 1'b1;
	endfunction

	function automatic void advance_pixel();
		int dx2, dy2;
		dx2 = 2 * span_x;
		dy2 = 2 * span_ay;
		case (octant)
			mlr_pkg::MODE_X_UP: begin
				if (decision < 0) begin
					cur_y = cur_y + 1'b1;
					decision += dx2 - dy2;
				end else begin
					decision -= dy2;
				end
				cur_x = cur_x + 1'b1;
			end
			mlr_pkg::MODE_Y_UP: begin
				if (decision >= 0) begin
					cur_x = cur_x + 1'b1;
					decision += dx2 - dy2;
				end else begin
					decision += dx2;
				end
				cur_y = cur_y + 1'b1;
			end
			mlr_pkg::MODE_Y_DOWN: begin
				if (decision < 0) begin
					cur_x = cur_x + 1'b1;
					decision += dy2 - dx2;
				end else begin
					decision -= dx2;
				end
				cur_y = cur_y - 1'b1;
			end
			default: begin
				if (decision > 0) begin
					cur_y = cur_y - 1'b1;
					decision += dy2 - dx2;
				end else begin
					decision += dy2;
				end
				cur_x = cur_x + 1'b1;
			end
		endcase
	endfunction

	function automatic void rasterize_request(request_t rq);
		pixel_t px;
		if (rq.kind == mlr_pkg::REQ_MOVE) begin
			pen_x = rq.x;
			pen_y = rq.y;
		end else if (rq.kind == mlr_pkg::REQ_LINE) begin
			start_line(rq.x, rq.y);
		end else if (rq.kind == mlr_pkg::REQ_STEP && drawing) begin
			px.x = cur_x;
			px.y = cur_y;
			px.last = (remaining <= 1);
			expected_pixels.push_back(px);
			if (remaining <= 1) begin
				remaining = 0;
				drawing = 1'b0;
			end else begin
				remaining--;
				advance_pixel();
			end
		end
	endfunction

	function automatic void add_request(logic [mlr_pkg::TUSER_BITS-1:0] kind, int x, int y);
		request_t rq;
		rq.kind = kind;
		rq.x = mlr_pkg::coord_t'(x);
		rq.y = mlr_pkg::coord_t'(y);
		request_queue.push_back(rq);
	endfunction

	function automatic int pick_coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 0;
		if (r < 20)
			return COORD_MAX;
		return $urandom_range(0, COORD_MAX);
	endfunction

	function automatic int near_coord(int c);
		int v;
		v = c + $urandom_range(0, 40) - 20;
		if (v < 0)
			v = 0;
		if (v > COORD_MAX)
			v = COORD_MAX;
		return v;
	endfunction

	function automatic bit side_idles();
		if (items_sent >= QUIET_FROM && items_sent < QUIET_TO)
			return 1'b0;
		return $urandom_range(0, 99) < IDLE_PCT;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (items_sent == PAUSE_AT && !pause_done) begin
				// hold until every pixel in flight has come out
				s_axis_tvalid <= 1'b0;
				if (!s_axis_tvalid && expected_pixels.size() == 0)
					pause_done = 1'b1;
			end else if (request_queue.size() != 0 && !side_idles()) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= tdata_t'({request_queue[0].y, request_queue[0].x});
				s_axis_tuser <= request_queue[0].kind;
				void'(request_queue.pop_front());
				items_sent <= items_sent + 1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// pixel receiver with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (items_sent >= HOLD_AT && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !side_idles();
		end
	end

	// prediction on accepted requests, check on accepted pixels
	always @(posedge clk) begin
		request_t rq;
		pixel_t   px;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				rq.kind = s_axis_tuser;
				rq.x = s_axis_tdata[CB-1:0];
				rq.y = s_axis_tdata[2*CB-1:CB];
				rasterize_request(rq);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected pixel x=%0d y=%0d last=%0b",
						m_axis_tdata[CB-1:0],
						m_axis_tdata[2*CB-1:CB], m_axis_tlast);
					error_count++;
				end else begin
					px = expected_pixels.pop_front();
					if (m_axis_tdata[CB-1:0] !== px.x) begin
						$error("pixel_x: expected %0d, got %0d", px.x,
							m_axis_tdata[CB-1:0]);
						error_count++;
					end
					if (m_axis_tdata[2*CB-1:CB] !== px.y) begin
						$error("pixel_y: expected %0d, got %0d", px.y,
							m_axis_tdata[2*CB-1:CB]);
						error_count++;
					end
					if (m_axis_tlast !== px.last) begin
						$error("last_pixel: expected %0b, got %0b", px.last, m_axis_tlast);
						error_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[midpoint_line_rasterizer] ERROR");
			$finish;
		end
	end

	initial begin
		int counted, px, py, ex, ey, major, nsteps, adx, ady, r, i;
		pen_x = '0; pen_y = '0; cur_x = '0; cur_y = '0;
		decision = 0; remaining = 0; span_x = 0; span_ay = 0;
		octant = mlr_pkg::MODE_X_UP; drawing = 1'b0;

		// directed: idle step, unused code, zero length, extremes, all four modes
		add_request(mlr_pkg::REQ_STEP, 0, 0);
		add_request(REQ_UNUSED, COORD_MAX, 0);
		add_request(mlr_pkg::REQ_MOVE, COORD_MAX, COORD_MAX);
		add_request(mlr_pkg::REQ_LINE, COORD_MAX, COORD_MAX);
		add_request(mlr_pkg::REQ_STEP, 0, COORD_MAX);
		add_request(mlr_pkg::REQ_LINE, 0, 0);
		add_request(mlr_pkg::REQ_STEP, 0, 0);
		add_request(mlr_pkg::REQ_STEP, 0, 0);
		add_request(mlr_pkg::REQ_MOVE, 0, COORD_MAX);
		add_request(mlr_pkg::REQ_STEP, 0, 0);
		add_request(mlr_pkg::REQ_LINE, COORD_MAX, 0);
		add_request(mlr_pkg::REQ_STEP, 0, 0);
		add_request(mlr_pkg::REQ_MOVE, 10, 10);
		add_request(mlr_pkg::REQ_LINE, 10, 13);
		for (i = 0; i < 4; i++)
			add_request(mlr_pkg::REQ_STEP, 0, 0);
		add_request(mlr_pkg::REQ_LINE, 10, 7);
		add_request(mlr_pkg::REQ_STEP, 0, 0);
		add_request(mlr_pkg::REQ_LINE, 13, 12);
		add_request(mlr_pkg::REQ_STEP, 0, 0);
		add_request(mlr_pkg::REQ_LINE, 7, 13);
		add_request(mlr_pkg::REQ_STEP, 0, 0);

		// random: mostly move, line and a run of steps; the rest is noise
		counted = 0;
		px = 10;
		py = 10;
		while (counted < TARGET_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				if ($urandom_range(0, 3) != 0) begin
					px = pick_coord();
					py = pick_coord();
					add_request(mlr_pkg::REQ_MOVE, px, py);
					counted++;
				end
				if ($urandom_range(0, 19) == 0) begin
					ex = pick_coord();
					ey = pick_coord();
				end else begin
					ex = near_coord(px);
					ey = near_coord(py);
				end
				add_request(mlr_pkg::REQ_LINE, ex, ey);
				counted++;
				adx = (ex > px) ? ex - px : px - ex;
				ady = (ey > py) ? ey - py : py - ey;
				major = (adx > ady) ? adx : ady;
				r = $urandom_range(0, 99);
				if (major > 40)
					nsteps = $urandom_range(1, 30);
				else if (r < 70)
					nsteps = major;
				else if (r < 85)
					nsteps = major + $urandom_range(1, 3);
				else
					nsteps = $urandom_range(0, major);
				for (i = 0; i < nsteps; i++) begin
					if ($urandom_range(0, 49) == 0) begin
						px = pick_coord();
						py = pick_coord();
						add_request(mlr_pkg::REQ_MOVE, px, py);
						counted++;
					end
					add_request(mlr_pkg::REQ_STEP, $urandom_range(0, COORD_MAX),
						$urandom_range(0, COORD_MAX));
					if (i < major)
						counted++;
				end
			end else begin
				r = $urandom_range(0, 3);
				ex = pick_coord();
				ey = pick_coord();
				add_request(r[mlr_pkg::TUSER_BITS-1:0], ex, ey);
				if (r == mlr_pkg::REQ_MOVE) begin
					px = ex;
					py = ey;
				end
				if (r == mlr_pkg::REQ_MOVE || r == mlr_pkg::REQ_LINE)
					counted++;
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (request_queue.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_pixels.size() == 0)
			$display("[midpoint_line_rasterizer] OK");
		else
			$display("[midpoint_line_rasterizer] ERROR");
		$finish;
	end

endmodule

### midpoint_line_rasterizer.f
hw/rtl/mlr_pkg.sv
hw/rtl/midpoint_line_rasterizer.sv
tb/sv/tb.sv
